/* sv/crcf_pkg.sv */
// Shared types, constants and the CRC-8 step function for the serial frame coder.
package crcf_pkg;

    localparam int CRC_W = 8;

    localparam logic [CRC_W-1:0] CRC_INIT   = 8'h00;
    localparam logic [CRC_W-1:0] POLY_RESET = 8'h07;
    localparam logic [CRC_W-1:0] CRC_MSB    = 8'h80;

    // the front's seen_reg saturates here; also the number of CRC bits appended
    localparam logic [3:0] DELAY_BITS = 4'd8;

    // register index, taken from paddr[2]
    localparam logic REG_POLY = 1'b0;
    localparam logic REG_DIR  = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_CHECK  = 1'b1;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic             direction;
    } cfg_t;

    // one entry of the queue between front and back
    typedef struct packed {
        logic             is_crc;   // data bit followed by 8 CRC bits
        logic             bit_val;
        logic             present;
        logic             last;
        logic             ok;
        logic             shrt;
        logic [CRC_W-1:0] crc;
    } cmd_t;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic             din,
                                                  input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] shifted;
        logic             fb;
        fb      = ((crc & CRC_MSB) != CRC_INIT) ^ din;
        shifted = {crc[CRC_W-2:0], 1'b0};
        return fb ? (shifted ^ poly) : shifted;
    endfunction

endpackage

/* sv/crc8_serial_frame_coder.sv */
// Top level of the bit-serial CRC-8 frame coder: config registers, front, queue, back.
//
//  Channel   Handshake          Payload
//  -------   ----------------   --------------------------------------------------
//  input     s_valid / s_ready  s_data_bit, s_frame_end
//  result    m_valid / m_ready  m_bit_out, m_bit_present, m_last_out, m_check_ok,
//                               m_frame_short
//  config    APB psel/penable   paddr (3 bits), pwdata / prdata (32 bits), pready = 1
//
// Cycles: one input item per cycle while the queue has space; the front updates the CRC and
//   delay line in the cycle it accepts the item. Results leave at up to one per cycle from
//   the output register, so an encode frame end (nine results) holds the back end while
//   they leave; the FIFO_DEPTH-entry queue lets the front keep accepting meanwhile.
// Reset: synchronous, active low; polynomial 0x07, encode direction, frame state clear.
// Stalls: s_ready drops only when the queue is full; m_ready low holds the output item.
module crc8_serial_frame_coder import crcf_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_data_bit,
    input  logic        s_frame_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_bit_out,
    output logic        m_bit_present,
    output logic        m_last_out,
    output logic        m_check_ok,
    output logic        m_frame_short,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    logic cfg_write;

    logic accept;
    logic fifo_push;
    cmd_t push_cmd;
    logic fifo_pop;
    logic fifo_full;
    logic fifo_not_empty;
    cmd_t head_cmd;

    // APB: register index is paddr[2], byte lanes below it are ignored
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_DIR) ? {31'd0, cfg_reg.direction}
                                             : {24'd0, cfg_reg.polynomial};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polynomial <= POLY_RESET;
            cfg_reg.direction  <= DIR_ENCODE;
        end else if (cfg_write) begin
            if (paddr[2] == REG_POLY) begin
                cfg_reg.polynomial <= pwdata[CRC_W-1:0];
            end else begin
                cfg_reg.direction <= pwdata[0];
            end
        end
    end

    // input side only waits on queue space
    assign s_ready = ~fifo_full;
    assign accept  = s_valid & s_ready;

    crcf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept    (accept),
        .data_bit  (s_data_bit),
        .frame_end (s_frame_end),
        .push      (fifo_push),
        .cmd       (push_cmd)
    );

    crcf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_cmd  (push_cmd),
        .pop       (fifo_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head      (head_cmd)
    );

    crcf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (fifo_not_empty),
        .head          (head_cmd),
        .pop           (fifo_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bit_out     (m_bit_out),
        .m_bit_present (m_bit_present),
        .m_last_out    (m_last_out),
        .m_check_ok    (m_check_ok),
        .m_frame_short (m_frame_short)
    );

    // queue never overflows: front only pushes on an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> !fifo_full)
        else $error("command queue push while full");

    // pop only with a valid head
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> fifo_not_empty)
        else $error("command queue pop while empty");

    // status flags and status-only items appear only on a frame's final item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_check_ok || m_frame_short || !m_bit_present)) |-> m_last_out)
        else $error("status outside final item");

    // a short frame never reports a CRC match, and a status-only item carries bit 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_check_ok && m_frame_short) && (m_bit_present || !m_bit_out))
        else $error("inconsistent result status");

endmodule

/* sv/crcf_front.sv */
// Front end: accepts bits, runs the CRC and (in check mode) the delay line, emits result commands.
module crcf_front import crcf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic accept,
    input  logic data_bit,
    input  logic frame_end,
    output logic push,
    output cmd_t cmd
);

    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [CRC_W-1:0] delay_reg, delay_next;
    logic [3:0]       seen_reg, seen_next;

    logic             release_bit;
    logic             oldest;
    logic [CRC_W-1:0] enc_crc;
    logic [CRC_W-1:0] chk_crc;
    logic [CRC_W-1:0] chk_delay;
    logic [3:0]       chk_seen;
    logic             shrt;

    always_comb begin
        enc_crc     = crc_step(crc_reg, data_bit, cfg.polynomial);
        release_bit = (seen_reg >= DELAY_BITS);
        oldest      = delay_reg[CRC_W-1];
        chk_crc     = release_bit ? crc_step(crc_reg, oldest, cfg.polynomial) : crc_reg;
        chk_delay   = {delay_reg[CRC_W-2:0], data_bit};
        chk_seen    = release_bit ? seen_reg : seen_reg + 4'd1;
        shrt        = (chk_seen < DELAY_BITS);

        cmd         = '0;
        push        = 1'b0;
        crc_next    = crc_reg;
        delay_next  = delay_reg;
        seen_next   = seen_reg;

        if (cfg.direction == DIR_ENCODE) begin
            cmd.bit_val = data_bit;
            cmd.present = 1'b1;
            cmd.is_crc  = frame_end;
            cmd.crc     = enc_crc;
            push        = accept;
            crc_next    = enc_crc;
        end else begin
            cmd.bit_val = release_bit & oldest;
            cmd.present = release_bit;
            cmd.last    = frame_end;
            cmd.shrt    = frame_end & shrt;
            cmd.ok      = frame_end & ~shrt & (chk_crc == chk_delay);
            push        = accept & (release_bit | frame_end);
            crc_next    = chk_crc;
            delay_next  = chk_delay;
            seen_next   = chk_seen;
        end

        if (frame_end) begin
            crc_next   = CRC_INIT;
            delay_next = CRC_INIT;
            seen_next  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_INIT;
            delay_reg <= CRC_INIT;
            seen_reg  <= 4'd0;
        end else if (accept) begin
            crc_reg   <= crc_next;
            delay_reg <= delay_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

/* sv/crcf_fifo.sv */
// Small command queue between front and back ends.
module crcf_fifo import crcf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/crcf_back.sv */
// Back end: expands queued commands into result items behind an output register.
module crcf_back import crcf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic head_valid,
    input  cmd_t head,
    output logic pop,
    output logic m_valid,
    input  logic m_ready,
    output logic m_bit_out,
    output logic m_bit_present,
    output logic m_last_out,
    output logic m_check_ok,
    output logic m_frame_short
);

    logic       valid_reg, valid_next;
    logic [3:0] phase_reg, phase_next;
    logic       load;
    logic [2:0] crc_idx;
    logic       res_bit, res_present, res_last, res_ok, res_shrt;

    logic bit_reg, present_reg, last_reg, ok_reg, shrt_reg;

    always_comb begin
        load    = head_valid & (~valid_reg | m_ready);
        crc_idx = 3'(DELAY_BITS - phase_reg);

        res_bit     = head.bit_val;
        res_present = head.present;
        res_last    = head.last;
        res_ok      = head.ok;
        res_shrt    = head.shrt;
        if (head.is_crc && phase_reg != 4'd0) begin
            res_bit     = head.crc[crc_idx];
            res_present = 1'b1;
            res_last    = (phase_reg == DELAY_BITS);
            res_ok      = 1'b0;
            res_shrt    = 1'b0;
        end else if (head.is_crc) begin
            res_last = 1'b0;
        end

        pop        = load & (~head.is_crc | (phase_reg == DELAY_BITS));
        phase_next = phase_reg;
        if (load && head.is_crc) begin
            phase_next = (phase_reg == DELAY_BITS) ? 4'd0 : phase_reg + 4'd1;
        end
        valid_next = load | (valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 4'd0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bit_reg     <= res_bit;
            present_reg <= res_present;
            last_reg    <= res_last;
            ok_reg      <= res_ok;
            shrt_reg    <= res_shrt;
        end
    end

    assign m_valid       = valid_reg;
    assign m_bit_out     = bit_reg;
    assign m_bit_present = present_reg;
    assign m_last_out    = last_reg;
    assign m_check_ok    = ok_reg;
    assign m_frame_short = shrt_reg;

endmodule
